### hdl/vtts_pkg.sv
// vtts_pkg: shared types and constants for the visual target tracking setpoint unit
`default_nettype none

package vtts_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_TAKEOFF_X    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TAKEOFF_Y    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TAKEOFF_Z    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LATERAL_STEP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DESCENT_STEP = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CLIMB_STEP   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_HEIGHT   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_HEIGHT   = 3'd7;

  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_TRACK  = 2'd1;
  localparam logic [1:0] MODE_LOST   = 2'd2;

  localparam int STEP_W    = 31;
  localparam int DIST_W    = 12;
  localparam int PROD_W    = STEP_W + DIST_W;
  localparam int DIV_STEPS = 31;
  localparam int CNT_W     = 5;

  typedef struct packed {
    logic [8:0]         target_px;
    logic [7:0]         target_py;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] setpoint_x;
    logic signed [31:0] setpoint_y;
    logic signed [31:0] setpoint_z;
    logic [1:0]         mode;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic classify;
    logic mult;
    logic prep;
    logic div_step;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/visual_target_tracking_setpoint_unit.sv
// visual_target_tracking_setpoint_unit: top level of the tracking setpoint generator
//
//   port group   direction  handshake          payload
//   in_*         input      in_valid/in_ready  in_item_t (pixel, vehicle position)
//   out_*        output     out_valid/out_ready out_item_t (setpoint, mode)
//   cfg_*        input      cfg_we             cfg_addr, cfg_wdata (8 registers)
//
// one tick runs capture, classify and finish when no ratio step is needed; when one is,
// it also runs the multiply, prepare and 31-step restoring divide of the ratio datapath
// a new transfer is taken in the cycle after the previous result is registered
// a result waiting on out_ready holds the block in its final state until taken
// synchronous active-low reset restores register defaults and search mode
`default_nettype none

module visual_target_tracking_setpoint_unit
  import vtts_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 320,
  parameter int IMAGE_HEIGHT = 240
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  vtts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  vtts_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hdl/vtts_ctrl.sv
// vtts_ctrl: sequencing state machine and output handshake
`default_nettype none

module vtts_ctrl
  import vtts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CLASSIFY = 6'b000010,
    S_MULT     = 6'b000100,
    S_PREP     = 6'b001000,
    S_DIVIDE   = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // ratio step goes through the multiplier and divider first
    if (state_r == S_CLASSIFY && status.need_div) begin
      state_nxt = S_MULT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hdl/vtts_datapath.sv
// vtts_datapath: config registers, pixel classification, ratio multiply/divide, setpoint state
`default_nettype none

module vtts_datapath
  import vtts_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 320,
  parameter int IMAGE_HEIGHT = 240
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctl_cmd_t              cmd,
  output dp_status_t                 status,
  input  wire in_item_t              in_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output out_item_t                  out_data
);

  localparam int PIX_W = 14;
  localparam int CMP_W = 20;
  localparam int MARGIN = 10;
  localparam int SLOPE_NUM = 11;
  localparam int SLOPE_DEN = 15;

  localparam logic signed [PIX_W-1:0] CX    = PIX_W'(IMAGE_WIDTH / 2);
  localparam logic signed [PIX_W-1:0] CY    = PIX_W'(IMAGE_HEIGHT / 2);
  localparam logic signed [PIX_W-1:0] CX_LO = PIX_W'(IMAGE_WIDTH / 2 - MARGIN);
  localparam logic signed [PIX_W-1:0] CX_HI = PIX_W'(IMAGE_WIDTH / 2 + MARGIN);
  localparam logic signed [PIX_W-1:0] CY_LO = PIX_W'(IMAGE_HEIGHT / 2 - MARGIN);
  localparam logic signed [PIX_W-1:0] CY_HI = PIX_W'(IMAGE_HEIGHT / 2 + MARGIN);
  localparam logic signed [CMP_W-1:0] K_NUM = CMP_W'(SLOPE_NUM);
  localparam logic signed [CMP_W-1:0] K_DEN = CMP_W'(SLOPE_DEN);
  localparam logic signed [CMP_W-1:0] H15   = CMP_W'(SLOPE_DEN * IMAGE_HEIGHT);
  localparam logic signed [CMP_W-1:0] W11   = CMP_W'(SLOPE_NUM * IMAGE_WIDTH);

  localparam logic signed [33:0] SUM_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SUM_MIN = 34'sh3_8000_0000;

  typedef enum logic [1:0] {
    RULE_NONE   = 2'd0,
    RULE_QUAD   = 2'd1,
    RULE_CENTRE = 2'd2
  } rule_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > SUM_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SUM_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] step_add(input logic signed [31:0] base,
                                                  input logic [STEP_W-1:0] mag,
                                                  input logic neg);
    logic signed [33:0] b34;
    logic signed [33:0] m34;
    b34 = 34'(base);
    m34 = $signed({3'b000, mag});
    return sat32(neg ? (b34 - m34) : (b34 + m34));
  endfunction

  // configuration registers
  logic signed [31:0]  takeoff_x_r, takeoff_y_r, takeoff_z_r;
  logic [STEP_W-1:0]   lateral_step_r, descent_step_r, climb_step_r;
  logic signed [31:0]  min_height_r, max_height_r;

  // tick state
  logic [1:0]          mode_r, mode_nxt;
  logic signed [31:0]  hold_r, hold_nxt;
  logic signed [31:0]  last_x_r, last_y_r, last_z_r;
  logic signed [31:0]  sp_x, sp_y, sp_z;

  // per-item work registers
  in_item_t            in_r;
  rule_t               rule_r, rule_nxt;
  logic                lat_x_r, lat_x_nxt;
  logic                neg_x_r, neg_y_r;
  logic [DIST_W-1:0]   num_r, num_nxt, den_r, den_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [DIST_W-1:0]   rem_r;
  logic [STEP_W-1:0]   quo_r;
  logic                sat_r;
  logic [CNT_W-1:0]    cnt_r;

  // classification
  logic signed [PIX_W-1:0] px_s, py_s, ax_s, ay_s;
  logic signed [CMP_W-1:0] px_c, py_c, px11, py15;
  logic lo_x, hi_x, lo_y, hi_y, left, right, top, bottom;
  logic q1, q2, q3, q4, centre;
  logic c1, c2, c3, c4;

  always_comb begin
    px_s   = $signed({5'b0, in_r.target_px});
    py_s   = $signed({6'b0, in_r.target_py});
    px_c   = $signed({11'b0, in_r.target_px});
    py_c   = $signed({12'b0, in_r.target_py});
    px11   = K_NUM * px_c;
    py15   = K_DEN * py_c;
    lo_x   = (px_s > 0) && (px_s < CX);
    hi_x   = px_s > CX;
    lo_y   = (py_s > 0) && (py_s < CY);
    hi_y   = py_s > CY;
    left   = px_s < CX_LO;
    right  = px_s > CX_HI;
    top    = py_s < CY_LO;
    bottom = py_s > CY_HI;
    q1     = (left || top) && lo_x && lo_y;
    q2     = (left || bottom) && lo_x && hi_y;
    q3     = (right || top) && hi_x && lo_y;
    q4     = (right || bottom) && hi_x && hi_y;
    centre = (px_s > CX_LO) && (py_s > CY_LO) && (px_s < CX_HI) && (py_s < CY_HI);
    c1     = py15 > px11;
    c2     = py15 < (H15 - px11);
    c3     = py15 > (W11 - px11);
    c4     = py15 < (H15 - (W11 - px11));
    ax_s   = hi_x ? (px_s - CX) : (CX - px_s);
    ay_s   = hi_y ? (py_s - CY) : (CY - py_s);

    if (q1 || q2 || q3 || q4) begin
      rule_nxt = RULE_QUAD;
    end else if (centre) begin
      rule_nxt = RULE_CENTRE;
    end else begin
      rule_nxt = RULE_NONE;
    end
    lat_x_nxt = (q1 && left && c1) || (q2 && left && c2) ||
                (q3 && right && c3) || (q4 && right && c4);
    num_nxt   = lat_x_nxt ? ay_s[DIST_W-1:0] : ax_s[DIST_W-1:0];
    den_nxt   = lat_x_nxt ? ax_s[DIST_W-1:0] : ay_s[DIST_W-1:0];
  end

  // restoring divider, one quotient bit per cycle
  logic [DIST_W:0]     trial;
  logic                trial_ge;
  logic [DIST_W:0]     trial_sub;
  logic [STEP_W-1:0]   ratio;

  always_comb begin
    trial     = {rem_r, quo_r[STEP_W-1]};
    trial_ge  = trial >= {1'b0, den_r};
    trial_sub = trial - {1'b0, den_r};
    ratio     = sat_r ? '1 : quo_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.classify) begin
      rule_r  <= rule_nxt;
      lat_x_r <= lat_x_nxt;
      neg_x_r <= hi_y;
      neg_y_r <= hi_x;
      num_r   <= num_nxt;
      den_r   <= den_nxt;
    end
    if (cmd.mult) begin
      prod_r <= PROD_W'(lateral_step_r) * PROD_W'(num_r);
    end
    if (cmd.prep) begin
      rem_r <= prod_r[PROD_W-1:STEP_W];
      quo_r <= prod_r[STEP_W-1:0];
      sat_r <= prod_r[PROD_W-1:STEP_W] >= den_r;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[DIST_W-1:0] : trial[DIST_W-1:0];
      quo_r <= {quo_r[STEP_W-2:0], trial_ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign status.need_div = (rule_nxt == RULE_QUAD) && (mode_r != MODE_LOST);
  assign status.div_last = cnt_r == CNT_W'(DIV_STEPS - 1);

  // tick update
  logic                seen, gone;
  logic signed [31:0]  quad_x, quad_y, centre_z, lost_z, dn_z, up_z;
  logic signed [31:0]  trk_x, trk_y, trk_z;
  logic                trk_hit, trk_hold;

  always_comb begin
    seen     = (in_r.target_px != '0) && (in_r.target_py != '0);
    gone     = (in_r.target_px == '0) && (in_r.target_py == '0);
    quad_x   = step_add(in_r.pos_x, lat_x_r ? lateral_step_r : ratio, neg_x_r);
    quad_y   = step_add(in_r.pos_y, lat_x_r ? ratio : lateral_step_r, neg_y_r);
    dn_z     = step_add(in_r.pos_z, descent_step_r, 1'b1);
    up_z     = step_add(in_r.pos_z, climb_step_r, 1'b0);
    centre_z = (dn_z < min_height_r) ? min_height_r : dn_z;
    lost_z   = (up_z > max_height_r) ? max_height_r : up_z;

    trk_hit  = 1'b0;
    trk_hold = 1'b0;
    trk_x    = in_r.pos_x;
    trk_y    = in_r.pos_y;
    trk_z    = centre_z;
    case (rule_r)
      RULE_QUAD: begin
        trk_hit = 1'b1;
        trk_x   = quad_x;
        trk_y   = quad_y;
        trk_z   = hold_r;
      end
      RULE_CENTRE: begin
        trk_hit  = 1'b1;
        trk_hold = 1'b1;
      end
      default: begin
        trk_hit = 1'b0;
      end
    endcase

    sp_x     = last_x_r;
    sp_y     = last_y_r;
    sp_z     = last_z_r;
    mode_nxt = mode_r;
    hold_nxt = hold_r;
    if (mode_r == MODE_LOST) begin
      sp_x = in_r.pos_x;
      sp_y = in_r.pos_y;
      sp_z = lost_z;
      if (seen) begin
        hold_nxt = lost_z;
        mode_nxt = MODE_TRACK;
      end
    end else if (mode_r == MODE_TRACK) begin
      if (trk_hit) begin
        sp_x = trk_x;
        sp_y = trk_y;
        sp_z = trk_z;
      end
      if (trk_hold) begin
        hold_nxt = centre_z;
      end
      if (gone) begin
        mode_nxt = MODE_LOST;
        sp_x     = in_r.pos_x;
        sp_y     = in_r.pos_y;
        sp_z     = lost_z;
      end
    end else begin
      mode_nxt = MODE_SEARCH;
      sp_x     = takeoff_x_r;
      sp_y     = takeoff_y_r;
      sp_z     = takeoff_z_r;
      if (seen) begin
        mode_nxt = MODE_TRACK;
        if (trk_hit) begin
          sp_x = trk_x;
          sp_y = trk_y;
          sp_z = trk_z;
        end
        if (trk_hold) begin
          hold_nxt = centre_z;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SEARCH;
      hold_r   <= 32'sd98304;
      last_x_r <= '0;
      last_y_r <= '0;
      last_z_r <= '0;
    end else if (cmd.commit) begin
      mode_r   <= mode_nxt;
      hold_r   <= hold_nxt;
      last_x_r <= sp_x;
      last_y_r <= sp_y;
      last_z_r <= sp_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      takeoff_x_r    <= '0;
      takeoff_y_r    <= '0;
      takeoff_z_r    <= 32'sd98304;
      lateral_step_r <= STEP_W'(6554);
      descent_step_r <= STEP_W'(13107);
      climb_step_r   <= STEP_W'(6554);
      min_height_r   <= 32'sd98304;
      max_height_r   <= 32'sd163840;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TAKEOFF_X:    takeoff_x_r    <= $signed(cfg_wdata);
        REG_TAKEOFF_Y:    takeoff_y_r    <= $signed(cfg_wdata);
        REG_TAKEOFF_Z:    takeoff_z_r    <= $signed(cfg_wdata);
        REG_LATERAL_STEP: lateral_step_r <= cfg_wdata[STEP_W-1:0];
        REG_DESCENT_STEP: descent_step_r <= cfg_wdata[STEP_W-1:0];
        REG_CLIMB_STEP:   climb_step_r   <= cfg_wdata[STEP_W-1:0];
        REG_MIN_HEIGHT:   min_height_r   <= $signed(cfg_wdata);
        REG_MAX_HEIGHT:   max_height_r   <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  assign out_data.setpoint_x = last_x_r;
  assign out_data.setpoint_y = last_y_r;
  assign out_data.setpoint_z = last_z_r;
  assign out_data.mode       = mode_r;

endmodule

`default_nettype wire

### test/vtts_checker.sv
// vtts_checker: follows every transfer of the setpoint unit, predicts each setpoint and compares
module vtts_checker
  import vtts_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 320,
  parameter int IMAGE_HEIGHT = 240
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    outstanding,
  output int                    errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint IW = IMAGE_WIDTH;
  localparam longint IH = IMAGE_HEIGHT;
  localparam longint CX = IMAGE_WIDTH / 2;
  localparam longint CY = IMAGE_HEIGHT / 2;
  localparam longint MARGIN = 10;
  localparam longint RISE = 11;
  localparam longint RUN = 15;
  localparam longint INT_MAX = 64'sd2147483647;
  localparam longint INT_MIN = -64'sd2147483648;

  longint     org_x, org_y, org_z;
  longint     lat_step, dsc_step, clb_step;
  longint     floor_z, ceil_z;
  logic [1:0] mode_q;
  longint     hold_z, sp_x, sp_y, sp_z;
  out_item_t  setpoint_q[$];
  int         result_idx;

  task automatic report_error(string msg);
    if (errors < 100) $display("%0t ns: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint clamp32(longint v);
    if (v > INT_MAX) return INT_MAX;
    if (v < INT_MIN) return INT_MIN;
    return v;
  endfunction

  function automatic longint scaled_step(longint a, longint b);
    longint q;
    if (a <= 0 || b <= 0) return 0;
    q = lat_step * a / b;
    return (q > INT_MAX) ? INT_MAX : q;
  endfunction

  function automatic void steer(longint px, longint py, longint x, longint y, longint z);
    bit lo_x, hi_x, lo_y, hi_y, left, right, top, bottom;
    longint dx, dy, nz;
    lo_x   = px > 0 && px < CX;
    hi_x   = px > CX;
    lo_y   = py > 0 && py < CY;
    hi_y   = py > CY;
    left   = px < CX - MARGIN;
    right  = px > CX + MARGIN;
    top    = py < CY - MARGIN;
    bottom = py > CY + MARGIN;
    if ((left || top) && lo_x && lo_y) begin
      if (left && RUN * py > RISE * px) begin
        dx = lat_step;
        dy = scaled_step(CY - py, CX - px);
      end else begin
        dx = scaled_step(CX - px, CY - py);
        dy = lat_step;
      end
    end else if ((left || bottom) && lo_x && hi_y) begin
      if (left && RUN * py < RUN * IH - RISE * px) begin
        dx = -lat_step;
        dy = scaled_step(py - CY, CX - px);
      end else begin
        dx = -scaled_step(CX - px, py - CY);
        dy = lat_step;
      end
    end else if ((right || top) && hi_x && lo_y) begin
      if (right && RUN * py > RISE * (IW - px)) begin
        dx = lat_step;
        dy = -scaled_step(CY - py, px - CX);
      end else begin
        dx = scaled_step(px - CX, CY - py);
        dy = -lat_step;
      end
    end else if ((right || bottom) && hi_x && hi_y) begin
      if (right && RUN * py < RUN * IH - RISE * (IW - px)) begin
        dx = -lat_step;
        dy = -scaled_step(py - CY, px - CX);
      end else begin
        dx = -scaled_step(px - CX, py - CY);
        dy = -lat_step;
      end
    end else if (px > CX - MARGIN && py > CY - MARGIN &&
                 px < CX + MARGIN && py < CY + MARGIN) begin
      nz = clamp32(z - dsc_step);
      if (nz < floor_z) nz = floor_z;
      hold_z = nz;
      sp_x = clamp32(x);
      sp_y = clamp32(y);
      sp_z = nz;
      return;
    end else begin
      return;
    end
    sp_x = clamp32(x + dx);
    sp_y = clamp32(y + dy);
    sp_z = clamp32(hold_z);
  endfunction

  function automatic out_item_t next_setpoint(in_item_t it);
    longint    px, py, x, y, z, nz;
    bit        seen, gone;
    out_item_t res;
    px   = longint'(it.target_px);
    py   = longint'(it.target_py);
    x    = longint'($signed(it.pos_x));
    y    = longint'($signed(it.pos_y));
    z    = longint'($signed(it.pos_z));
    seen = px > 0 && py > 0;
    gone = px == 0 && py == 0;
    if (mode_q != MODE_TRACK && mode_q != MODE_LOST) begin
      mode_q = MODE_SEARCH;
      sp_x = org_x;
      sp_y = org_y;
      sp_z = org_z;
      if (seen) begin
        mode_q = MODE_TRACK;
        steer(px, py, x, y, z);
      end
    end else if (mode_q == MODE_TRACK) begin
      steer(px, py, x, y, z);
      if (gone) mode_q = MODE_LOST;
    end
    if (mode_q == MODE_LOST) begin
      nz = clamp32(z + clb_step);
      if (nz > ceil_z) nz = ceil_z;
      sp_x = x;
      sp_y = y;
      sp_z = nz;
      if (seen) begin
        hold_z = nz;
        mode_q = MODE_TRACK;
      end
    end
    res.setpoint_x = sp_x[31:0];
    res.setpoint_y = sp_y[31:0];
    res.setpoint_z = sp_z[31:0];
    res.mode       = mode_q;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      org_x    = 0;
      org_y    = 0;
      org_z    = 98304;
      lat_step = 6554;
      dsc_step = 13107;
      clb_step = 6554;
      floor_z  = 98304;
      ceil_z   = 163840;
      mode_q   = MODE_SEARCH;
      hold_z   = 98304;
      sp_x     = 0;
      sp_y     = 0;
      sp_z     = 0;
      setpoint_q.delete();
      result_idx = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TAKEOFF_X:    org_x    = longint'($signed(cfg_wdata));
          REG_TAKEOFF_Y:    org_y    = longint'($signed(cfg_wdata));
          REG_TAKEOFF_Z:    org_z    = longint'($signed(cfg_wdata));
          REG_LATERAL_STEP: lat_step = longint'(cfg_wdata[30:0]);
          REG_DESCENT_STEP: dsc_step = longint'(cfg_wdata[30:0]);
          REG_CLIMB_STEP:   clb_step = longint'(cfg_wdata[30:0]);
          REG_MIN_HEIGHT:   floor_z  = longint'($signed(cfg_wdata));
          REG_MAX_HEIGHT:   ceil_z   = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (setpoint_q.size() == 0) begin
          report_error($sformatf("result %0d: transfer with no setpoint expected", result_idx));
        end else begin
          want = setpoint_q.pop_front();
          if (out_data.setpoint_x !== want.setpoint_x)
            report_error($sformatf("result %0d setpoint_x: got %0d, expected %0d", result_idx,
                                   out_data.setpoint_x, want.setpoint_x));
          if (out_data.setpoint_y !== want.setpoint_y)
            report_error($sformatf("result %0d setpoint_y: got %0d, expected %0d", result_idx,
                                   out_data.setpoint_y, want.setpoint_y));
          if (out_data.setpoint_z !== want.setpoint_z)
            report_error($sformatf("result %0d setpoint_z: got %0d, expected %0d", result_idx,
                                   out_data.setpoint_z, want.setpoint_z));
          if (out_data.mode !== want.mode)
            report_error($sformatf("result %0d mode: got %0d, expected %0d", result_idx,
                                   out_data.mode, want.mode));
        end
        result_idx++;
      end
      if (in_valid && in_ready) setpoint_q.push_back(next_setpoint(in_data));
    end
    outstanding <= setpoint_q.size();
  end

endmodule

### test/testbench.sv
// testbench: directed and random tracking ticks through the setpoint unit, with the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vtts_pkg::*;

  localparam int ITEMS_PER_PHASE = 225;
  localparam int NUM_PHASES      = 6;
  localparam int IDLE_LIMIT      = 4000;
  localparam int LONG_HOLD       = 600;
  localparam logic [31:0] ONE_M  = 32'd65536;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    outstanding;
  int                    errors;
  int                    burst_left = 0;
  int                    idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  visual_target_tracking_setpoint_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  vtts_checker setpoint_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .errors      (errors)
  );

  function automatic in_item_t make_item(int px, int py, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z);
    in_item_t it;
    it.target_px = 9'(px);
    it.target_py = 8'(py);
    it.pos_x     = x;
    it.pos_y     = y;
    it.pos_z     = z;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord(int centre);
    case ($urandom_range(0, 11)) inside
      0:       return 32'h7FFFFFFF - 32'($urandom_range(0, 30000));
      1:       return 32'h80000000 + 32'($urandom_range(0, 30000));
      [2:3]:   return $urandom();
      default: return 32'(centre + int'($urandom_range(0, 1310720)) - 655360);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    int px, py;
    case ($urandom_range(0, 19)) inside
      [0:1]: begin
        px = 0;
        py = 0;
      end
      2: begin
        if ($urandom_range(0, 1)) begin
          px = 0;
          py = $urandom_range(1, 255);
        end else begin
          px = $urandom_range(1, 511);
          py = 0;
        end
      end
      3: begin
        px = $urandom_range(0, 511);
        py = $urandom_range(0, 255);
      end
      [4:7]: begin
        px = $urandom_range(145, 175);
        py = $urandom_range(105, 135);
      end
      default: begin
        px = $urandom_range(1, 319);
        py = $urandom_range(1, 239);
      end
    endcase
    return make_item(px, py, rand_coord(0), rand_coord(0), rand_coord(131072));
  endfunction

  task automatic offer(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(10, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(int phase);
    case (phase)
      1: begin
        write_reg(REG_TAKEOFF_X, 32'h7FFFFFFF);
        write_reg(REG_TAKEOFF_Y, 32'h80000000);
        write_reg(REG_TAKEOFF_Z, 32'h7FFFFFFF);
        write_reg(REG_LATERAL_STEP, 32'h7FFFFFFF);
        write_reg(REG_DESCENT_STEP, 32'h7FFFFFFF);
        write_reg(REG_CLIMB_STEP, 32'h7FFFFFFF);
        write_reg(REG_MIN_HEIGHT, 32'h80000000);
        write_reg(REG_MAX_HEIGHT, 32'h7FFFFFFF);
      end
      2: begin
        write_reg(REG_TAKEOFF_X, $urandom());
        write_reg(REG_TAKEOFF_Y, $urandom());
        write_reg(REG_TAKEOFF_Z, $urandom());
        write_reg(REG_LATERAL_STEP, {1'b0, 31'($urandom())});
        write_reg(REG_DESCENT_STEP, {1'b0, 31'($urandom())});
        write_reg(REG_CLIMB_STEP, {1'b0, 31'($urandom())});
        write_reg(REG_MIN_HEIGHT, $urandom());
        write_reg(REG_MAX_HEIGHT, $urandom());
      end
      3: begin
        write_reg(REG_TAKEOFF_X, 32'h80000000);
        write_reg(REG_TAKEOFF_Y, 32'h7FFFFFFF);
        write_reg(REG_TAKEOFF_Z, 32'h80000000);
        write_reg(REG_LATERAL_STEP, 32'd0);
        write_reg(REG_DESCENT_STEP, 32'd0);
        write_reg(REG_CLIMB_STEP, 32'd0);
        write_reg(REG_MIN_HEIGHT, 32'h7FFFFFFF);
        write_reg(REG_MAX_HEIGHT, 32'h80000000);
      end
      4: begin
        write_reg(REG_TAKEOFF_X, 32'($urandom_range(0, 1310720)) - 32'd655360);
        write_reg(REG_TAKEOFF_Y, 32'($urandom_range(0, 1310720)) - 32'd655360);
        write_reg(REG_TAKEOFF_Z, 32'($urandom_range(65536, 196608)));
        write_reg(REG_LATERAL_STEP, 32'($urandom_range(1, 40000)));
        write_reg(REG_DESCENT_STEP, 32'($urandom_range(1, 40000)));
        write_reg(REG_CLIMB_STEP, 32'($urandom_range(1, 40000)));
        write_reg(REG_MIN_HEIGHT, 32'd262144);
        write_reg(REG_MAX_HEIGHT, 32'd65536);
      end
      default: begin
        write_reg(REG_TAKEOFF_X, 32'($urandom_range(0, 1310720)) - 32'd655360);
        write_reg(REG_TAKEOFF_Y, 32'($urandom_range(0, 1310720)) - 32'd655360);
        write_reg(REG_TAKEOFF_Z, 32'($urandom_range(65536, 196608)));
        write_reg(REG_LATERAL_STEP, 32'($urandom_range(1000, 20000)));
        write_reg(REG_DESCENT_STEP, 32'($urandom_range(1000, 30000)));
        write_reg(REG_CLIMB_STEP, 32'($urandom_range(1000, 20000)));
        write_reg(REG_MIN_HEIGHT, 32'($urandom_range(65536, 131072)));
        write_reg(REG_MAX_HEIGHT, 32'($urandom_range(131072, 327680)));
      end
    endcase
  endtask

  // receiver: stall pattern of its own, with long hold-offs to back up the block
  initial begin : receiver
    int  style, span, cycles;
    bit  held;
    held   = 1'b0;
    cycles = 0;
    wait (rst_n);
    forever begin
      if ((!held && cycles > 3000) || $urandom_range(0, 59) == 0) begin
        held = 1'b1;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
        cycles += LONG_HOLD;
      end
      style = $urandom_range(0, 3);
      span  = $urandom_range(10, 200);
      repeat (span) begin
        @(posedge clk);
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 5) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
      cycles += span;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // search mode: lost, one coordinate zero
    offer(make_item(0, 0, ONE_M, 2 * ONE_M, 3 * ONE_M / 2));
    offer(make_item(5, 0, ONE_M, 2 * ONE_M, 3 * ONE_M / 2));
    offer(make_item(0, 7, ONE_M, 2 * ONE_M, 3 * ONE_M / 2));
    // detection at the centre, then each quadrant, the first two on both sides of the slope
    offer(make_item(160, 120, ONE_M, 2 * ONE_M, 2 * ONE_M));
    offer(make_item(20, 30, ONE_M, ONE_M, 2 * ONE_M));
    offer(make_item(100, 10, ONE_M, ONE_M, 2 * ONE_M));
    offer(make_item(10, 230, ONE_M, ONE_M, 2 * ONE_M));
    offer(make_item(100, 200, ONE_M, ONE_M, 2 * ONE_M));
    offer(make_item(300, 20, ONE_M, ONE_M, 2 * ONE_M));
    offer(make_item(200, 100, ONE_M, ONE_M, 2 * ONE_M));
    offer(make_item(310, 230, ONE_M, ONE_M, 2 * ONE_M));
    offer(make_item(200, 140, ONE_M, ONE_M, 2 * ONE_M));
    // centre line, margin edge, one coordinate zero: setpoint held
    offer(make_item(160, 50, 3 * ONE_M, 3 * ONE_M, 2 * ONE_M));
    offer(make_item(150, 120, 3 * ONE_M, 3 * ONE_M, 2 * ONE_M));
    offer(make_item(0, 50, 3 * ONE_M, 3 * ONE_M, 2 * ONE_M));
    // saturating sums and pixels beyond the image
    offer(make_item(300, 20, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    offer(make_item(10, 230, 32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    offer(make_item(511, 255, ONE_M, ONE_M, ONE_M));
    // loss, climb against the ceiling, reacquire
    offer(make_item(0, 0, ONE_M, ONE_M, 3 * ONE_M / 2));
    offer(make_item(0, 0, ONE_M, ONE_M, 32'h7FFFFFF0));
    offer(make_item(40, 40, ONE_M, ONE_M, 2 * ONE_M));
    offer(make_item(170, 130, ONE_M, ONE_M, 2 * ONE_M));
    offer(make_item(165, 115, ONE_M, ONE_M, ONE_M));
    offer(make_item(0, 0, ONE_M, ONE_M, 32'h80000000));
    offer(make_item(1, 1, 32'hFFFF0000, 32'hFFFF0000, ONE_M));

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      apply_setting(phase);
      repeat (ITEMS_PER_PHASE) offer(rand_item());
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
